FILE: hw/rtl/sibe_pkg.sv
// shared types, constants and encoding functions for the immediate byte encoder
package sibe_pkg;

    localparam int MAX_GROUPS = 5;
    localparam int GROUP_W    = 7;
    localparam int VALUE_W    = 32;
    localparam int LEN_W      = 3;

    localparam logic [7:0] IMM_MARK = 8'h80;

    // apb register indexes
    localparam logic REG_FLIP_OPCODE = 1'b0;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [LEN_W-1:0]   len_t;

    // one encoded constant: bytes[0] goes out first
    typedef struct packed {
        logic [MAX_GROUPS-1:0][7:0] bytes;
        len_t                       len;
    } entry_t;

    function automatic value_t reverse_bits(input value_t v);
        value_t r;
        r = '0;
        for (int i = 0; i < VALUE_W; i++)
        begin
            r[VALUE_W-1-i] = v[i];
        end
        return r;
    endfunction

    // shortest run of 7-bit groups, most significant group first
    function automatic entry_t encode(input value_t v);
        logic [MAX_GROUPS*GROUP_W-1:0]          sx;
        logic [MAX_GROUPS-1:0][GROUP_W-1:0]     grp;
        logic [MAX_GROUPS-1:0]                  need;
        len_t                                   n;
        len_t                                   gi;
        entry_t                                 e;
        sx = {{(MAX_GROUPS*GROUP_W-VALUE_W){v[VALUE_W-1]}}, v};
        for (int g = 0; g < MAX_GROUPS; g++)
        begin
            grp[g] = sx[g*GROUP_W +: GROUP_W];
        end
        need[0] = 1'b1;
        for (int g = 1; g < MAX_GROUPS; g++)
        begin
            need[g] = grp[g] != {GROUP_W{sx[g*GROUP_W-1]}};
        end
        n = len_t'(1);
        for (int g = 1; g < MAX_GROUPS; g++)
        begin
            if (need[g])
            begin
                n = len_t'(g + 1);
            end
        end
        e.bytes = '0;
        e.len   = n;
        for (int k = 0; k < MAX_GROUPS; k++)
        begin
            gi = n - len_t'(k) - len_t'(1);
            if (len_t'(k) < n)
            begin
                e.bytes[k] = IMM_MARK | {1'b0, grp[gi]};
            end
        end
        return e;
    endfunction

endpackage

FILE: hw/rtl/sibe_front.sv
// front end: encodes the plain and bit-reversed forms and keeps the shorter one
module sibe_front
    import sibe_pkg::*;
(
    input  value_t       value,
    input  logic [7:0]   flip_opcode,
    output entry_t       entry
);

    entry_t plain_enc;
    entry_t flip_enc;
    len_t   flip_len;

    always_comb
    begin
        plain_enc = encode(value);
        flip_enc  = encode(reverse_bits(value));
        flip_len  = flip_enc.len + len_t'(1);
        entry     = plain_enc;
        // ties go to the plain form
        if (flip_len < plain_enc.len)
        begin
            entry                          = flip_enc;
            entry.bytes[flip_enc.len[2:0]] = flip_opcode;
            entry.len                      = flip_len;
        end
    end

endmodule

FILE: hw/rtl/sibe_queue.sv
// short queue of encoded constants between front and back end
module sibe_queue
    import sibe_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   not_empty,
    output logic   full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign full      = count_reg == CNT_W'(DEPTH);

endmodule

FILE: hw/rtl/sibe_back.sv
// back end: sends the bytes of the head entry one beat at a time
module sibe_back
    import sibe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  entry_t      head,
    input  logic        head_valid,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [7:0]  code_byte,
    output logic        last,
    output logic        pop
);

    len_t idx_reg, idx_next;
    logic beat;

    assign out_valid = head_valid;
    assign code_byte = head.bytes[idx_reg];
    assign last      = idx_reg == head.len - len_t'(1);
    assign beat      = out_valid && out_ready;
    assign pop       = beat && last;

    always_comb
    begin
        idx_next = idx_reg;
        if (pop)
        begin
            idx_next = '0;
        end
        else if (beat)
        begin
            idx_next = idx_reg + len_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

FILE: hw/rtl/shortest_immediate_byte_encoder.sv
// top level of the shortest immediate byte encoder
// Each accepted 32-bit constant becomes a run of one to five bytes on the output,
// one byte per beat with last on the final one, so an item holds the output for
// as many beats as it has bytes; the output port at one byte per cycle while
// out_ready is high sets the sustained rate. Constants are encoded in the cycle
// they are accepted and wait in a QUEUE_DEPTH-entry queue, so a new constant is
// taken every cycle while the queue has room, even while earlier bytes are still
// being sent. The flip opcode register answers at apb addresses 0 to 3.
module shortest_immediate_byte_encoder
    import sibe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  code_byte,
    output logic        last
);

    logic [7:0] flip_opcode_reg, flip_opcode_next;
    entry_t     new_entry;
    entry_t     head;
    logic       head_valid;
    logic       full;
    logic       push;
    logic       pop;

    assign pready = 1'b1;

    always_comb
    begin
        flip_opcode_next = flip_opcode_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_FLIP_OPCODE))
        begin
            flip_opcode_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_opcode_reg <= '0;
        end
        else
        begin
            flip_opcode_reg <= flip_opcode_next;
        end
    end

    assign prdata = (paddr[2] == REG_FLIP_OPCODE) ? {24'd0, flip_opcode_reg} : 32'd0;

    assign in_ready = !full;
    assign push     = in_valid && in_ready;

    sibe_front u_front (
        .value       (value),
        .flip_opcode (flip_opcode_reg),
        .entry       (new_entry)
    );

    sibe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (new_entry),
        .pop        (pop),
        .head       (head),
        .not_empty  (head_valid),
        .full       (full)
    );

    sibe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .code_byte  (code_byte),
        .last       (last),
        .pop        (pop)
    );

endmodule

FILE: hw/rtl/sibe_checker.sv
// port-level checks for the immediate byte encoder, bound to the top level
module sibe_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  code_byte,
    input  logic        last
);

    // constants accepted whose last beat has not gone yet
    logic [3:0] open_reg, open_next;

    always_comb
    begin
        open_next = open_reg;
        if ((in_valid && in_ready) && !(out_valid && out_ready && last))
        begin
            open_next = open_reg + 4'd1;
        end
        else if (!(in_valid && in_ready) && (out_valid && out_ready && last))
        begin
            open_next = open_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_byte) && $stable(last))
        else $error("stalled output beat changed");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> open_reg != 4'd0)
        else $error("output beat with no constant outstanding");

    a_imm_mark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> code_byte[7])
        else $error("non-final byte lacks immediate mark");

    a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> open_reg != 4'd0)
        else $error("input stalled while nothing outstanding");

endmodule

bind shortest_immediate_byte_encoder sibe_checker u_sibe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_byte (code_byte),
    .last      (last)
);
